// ----- rtl/round_robin_thread_scheduler_defines.svh -----
// ----------------------------------------------------------------------------
// Round-robin thread scheduler: assertion macros
// Assertion macros used by the scheduler datapath (rrts_dp).
// ----------------------------------------------------------------------------
`ifndef ROUND_ROBIN_THREAD_SCHEDULER_DEFINES_SVH
`define ROUND_ROBIN_THREAD_SCHEDULER_DEFINES_SVH
`ifndef ASSERT_OFF
// Check a property on every clock edge outside reset.
`define RRTS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that a condition implies another in the next cycle.
`define RRTS_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define RRTS_ASSERT(label, prop, msg)
`define RRTS_ASSERT_NEXT(label, pre, post, msg)
`endif
`endif

// ----- rtl/rrts_pkg.sv -----
// ----------------------------------------------------------------------------
// Round-robin thread scheduler package
// Widths, event and outcome codes, and controller/datapath interface types.
// ----------------------------------------------------------------------------
package rrts_pkg;

  localparam int ID_W        = 4;
  localparam int CNT_W       = 5;
  localparam int KIND_W      = 2;
  localparam int OUTC_W      = 3;
  localparam int MAX_THREADS = 16;

  localparam logic [KIND_W-1:0] KIND_YIELD  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CREATE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EXIT   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_JOIN   = 2'd3;

  localparam logic [OUTC_W-1:0] OUT_SWITCHED = 3'd0;
  localparam logic [OUTC_W-1:0] OUT_STAY     = 3'd1;
  localparam logic [OUTC_W-1:0] OUT_DONE     = 3'd2;
  localparam logic [OUTC_W-1:0] OUT_CREATED  = 3'd3;
  localparam logic [OUTC_W-1:0] OUT_REFUSED  = 3'd4;

  typedef struct packed {
    logic              latch;
    logic              yield;
    logic              create;
    logic              splice;
    logic              remove;
    logic              mark_done;
    logic              enq_wait;
    logic              load_out;
    logic              created;
    logic [OUTC_W-1:0] outcome;
  } rrts_cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              single;
    logic              create_ok;
    logic              exit_ok;
    logic              join_valid;
    logic              join_done;
    logic              join_ok;
    logic              out_free;
  } rrts_status_t;

endpackage

// ----- rtl/rrts_ctrl.sv -----
// ----------------------------------------------------------------------------
// Scheduler controller
// Sequences one event through decide, splice, unlink, wait-list and result steps.
// ----------------------------------------------------------------------------
module rrts_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  rrts_pkg::rrts_status_t st,
  output rrts_pkg::rrts_cmd_t    cmd
);
  import rrts_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DECIDE = 6'b000010,
    S_SPLICE = 6'b000100,
    S_REMOVE = 6'b001000,
    S_WAIT   = 6'b010000,
    S_RESP   = 6'b100000
  } state_t;

  state_t            state_r, state_nxt;
  logic [OUTC_W-1:0] outcome_r, outcome_nxt;
  logic              created_r, created_nxt;
  logic              join_r, join_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt   = state_r;
    outcome_nxt = outcome_r;
    created_nxt = created_r;
    join_nxt    = join_r;
    cmd         = '0;
    cmd.outcome = outcome_r;
    cmd.created = created_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        outcome_nxt = OUT_REFUSED;
        created_nxt = 1'b0;
        join_nxt    = 1'b0;
        state_nxt   = S_RESP;
        unique case (st.kind)
          KIND_YIELD: begin
            cmd.yield   = 1'b1;
            outcome_nxt = st.single ? OUT_STAY : OUT_SWITCHED;
          end
          KIND_CREATE: begin
            if (st.create_ok) begin
              cmd.create  = 1'b1;
              created_nxt = 1'b1;
              outcome_nxt = OUT_CREATED;
            end
          end
          KIND_EXIT: begin
            if (st.exit_ok) begin
              outcome_nxt = OUT_SWITCHED;
              state_nxt   = S_SPLICE;
            end
          end
          KIND_JOIN: begin
            if (st.join_valid && st.join_done) begin
              outcome_nxt = OUT_DONE;
            end else if (st.join_ok) begin
              outcome_nxt = OUT_SWITCHED;
              join_nxt    = 1'b1;
              state_nxt   = S_REMOVE;
            end
          end
          default: ;
        endcase
      end
      S_SPLICE: begin
        cmd.splice = 1'b1;
        state_nxt  = S_REMOVE;
      end
      S_REMOVE: begin
        cmd.remove    = 1'b1;
        cmd.mark_done = !join_r;
        state_nxt     = join_r ? S_WAIT : S_RESP;
      end
      S_WAIT: begin
        cmd.enq_wait = 1'b1;
        state_nxt    = S_RESP;
      end
      S_RESP: begin
        if (st.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    outcome_r <= outcome_nxt;
    created_r <= created_nxt;
    join_r    <= join_nxt;
  end

endmodule

// ----- rtl/rrts_dp.sv -----
// ----------------------------------------------------------------------------
// Scheduler datapath
// Run list, wait lists, thread status and the result register.
// ----------------------------------------------------------------------------
`include "round_robin_thread_scheduler_defines.svh"

module rrts_dp #(
  parameter int MAX_THREADS = rrts_pkg::MAX_THREADS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [rrts_pkg::KIND_W-1:0] in_kind,
  input  logic [rrts_pkg::ID_W-1:0]   in_target_thread,
  input  rrts_pkg::rrts_cmd_t         cmd,
  output rrts_pkg::rrts_status_t      st,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [rrts_pkg::OUTC_W-1:0] out_outcome,
  output logic [rrts_pkg::ID_W-1:0]   out_current_thread,
  output logic [rrts_pkg::ID_W-1:0]   out_new_thread,
  output logic [rrts_pkg::CNT_W-1:0]  out_runnable_count
);
  import rrts_pkg::*;

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_THREADS);

  logic [ID_W-1:0]  link_next_r [MAX_THREADS];
  logic [ID_W-1:0]  link_prev_r [MAX_THREADS];
  logic [ID_W-1:0]  wait_head_r [MAX_THREADS];
  logic [ID_W-1:0]  wait_tail_r [MAX_THREADS];
  logic [CNT_W-1:0] wait_cnt_r  [MAX_THREADS];
  logic [MAX_THREADS-1:0] has_wait_r, done_r;

  logic [ID_W-1:0]   head_r, tail_r, cur_r, old_r;
  logic [CNT_W-1:0]  size_r, free_r;
  logic [KIND_W-1:0] kind_r;
  logic [ID_W-1:0]   tgt_r;

  logic              ovalid_r;
  logic [OUTC_W-1:0] oout_r;
  logic [ID_W-1:0]   ocur_r, onew_r;
  logic [CNT_W-1:0]  osize_r;

  logic [ID_W-1:0] succ, cprev, cnext, new_id;

  assign cnext  = link_next_r[cur_r];
  assign cprev  = link_prev_r[cur_r];
  assign succ   = (cur_r == tail_r) ? head_r : cnext;
  assign new_id = free_r[ID_W-1:0];

  always_comb begin
    st            = '0;
    st.kind       = kind_r;
    st.single     = (size_r == CNT_W'(1));
    st.create_ok  = (free_r < MAX_CNT);
    st.exit_ok    = (size_r > CNT_W'(1)) || has_wait_r[cur_r];
    st.join_valid = ({1'b0, tgt_r} < free_r);
    st.join_done  = done_r[tgt_r];
    st.join_ok    = st.join_valid && !done_r[tgt_r] && (tgt_r != cur_r) &&
                    (size_r > CNT_W'(1));
    st.out_free   = !ovalid_r || out_ready;
  end

  // control registers of the lists
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r     <= '0;
      tail_r     <= '0;
      cur_r      <= '0;
      size_r     <= CNT_W'(1);
      free_r     <= CNT_W'(1);
      has_wait_r <= '0;
      done_r     <= '0;
      ovalid_r   <= 1'b0;
    end else begin
      if (cmd.yield) begin
        cur_r <= succ;
      end
      if (cmd.create) begin
        tail_r <= new_id;
        size_r <= size_r + CNT_W'(1);
        free_r <= free_r + CNT_W'(1);
      end
      if (cmd.splice && has_wait_r[cur_r]) begin
        tail_r             <= wait_tail_r[cur_r];
        size_r             <= size_r + wait_cnt_r[cur_r];
        has_wait_r[cur_r]  <= 1'b0;
      end
      if (cmd.remove) begin
        if (cur_r == head_r) head_r <= cnext;
        if (cur_r == tail_r) tail_r <= cprev;
        size_r <= size_r - CNT_W'(1);
        cur_r  <= succ;
        if (cmd.mark_done) done_r[cur_r] <= 1'b1;
      end
      if (cmd.enq_wait) begin
        has_wait_r[tgt_r] <= 1'b1;
      end
      if (cmd.load_out) begin
        ovalid_r <= 1'b1;
      end else if (out_ready) begin
        ovalid_r <= 1'b0;
      end
    end
  end

  // link tables and payload registers
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      kind_r <= in_kind;
      tgt_r  <= in_target_thread;
    end
    if (cmd.create) begin
      link_prev_r[new_id] <= tail_r;
      link_next_r[tail_r] <= new_id;
    end
    if (cmd.splice && has_wait_r[cur_r]) begin
      link_prev_r[wait_head_r[cur_r]] <= tail_r;
      link_next_r[tail_r]             <= wait_head_r[cur_r];
    end
    if (cmd.remove) begin
      old_r <= cur_r;
      if (cur_r != head_r) link_next_r[cprev] <= cnext;
      if (cur_r != tail_r) link_prev_r[cnext] <= cprev;
    end
    if (cmd.enq_wait) begin
      if (has_wait_r[tgt_r]) begin
        link_next_r[wait_tail_r[tgt_r]] <= old_r;
        link_prev_r[old_r]              <= wait_tail_r[tgt_r];
        wait_cnt_r[tgt_r]               <= wait_cnt_r[tgt_r] + CNT_W'(1);
      end else begin
        wait_head_r[tgt_r] <= old_r;
        wait_cnt_r[tgt_r]  <= CNT_W'(1);
      end
      wait_tail_r[tgt_r] <= old_r;
    end
    if (cmd.load_out) begin
      oout_r  <= cmd.outcome;
      ocur_r  <= cur_r;
      onew_r  <= cmd.created ? (new_id - ID_W'(1)) : '0;
      osize_r <= size_r;
    end
  end

  assign out_valid          = ovalid_r;
  assign out_outcome        = oout_r;
  assign out_current_thread = ocur_r;
  assign out_new_thread     = onew_r;
  assign out_runnable_count = osize_r;

  `RRTS_ASSERT(a_size_range, (size_r != '0) && (size_r <= MAX_CNT), "run list size out of range")
  `RRTS_ASSERT(a_cur_not_done, !done_r[cur_r], "running thread is marked done")
  `RRTS_ASSERT_NEXT(a_create_grows, cmd.create, size_r == $past(size_r) + CNT_W'(1), "create did not grow run list")

endmodule

// ----- rtl/round_robin_thread_scheduler.sv -----
// Sequence: after an input is accepted, the controller runs decide, then splice and unlink for exit
// or unlink and wait-list for join, then loads the result once a pending result is taken on out_ready.
// Flow: one event at a time; a new input is accepted only after the result is loaded and the
// controller is back in idle.
// Reset: synchronous active-low rst_n; thread 0 runs alone, no result pending.
// ----------------------------------------------------------------------------
// Round-robin thread scheduler
// Run list with yield, create, exit and join; one result per event.
// ----------------------------------------------------------------------------
module round_robin_thread_scheduler #(
  parameter int MAX_THREADS = rrts_pkg::MAX_THREADS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [rrts_pkg::KIND_W-1:0] in_kind,
  input  logic [rrts_pkg::ID_W-1:0]   in_target_thread,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [rrts_pkg::OUTC_W-1:0] out_outcome,
  output logic [rrts_pkg::ID_W-1:0]   out_current_thread,
  output logic [rrts_pkg::ID_W-1:0]   out_new_thread,
  output logic [rrts_pkg::CNT_W-1:0]  out_runnable_count
);
  import rrts_pkg::*;

  rrts_cmd_t    cmd;
  rrts_status_t st;

  rrts_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  rrts_dp #(
    .MAX_THREADS (MAX_THREADS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_kind            (in_kind),
    .in_target_thread   (in_target_thread),
    .cmd                (cmd),
    .st                 (st),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_outcome        (out_outcome),
    .out_current_thread (out_current_thread),
    .out_new_thread     (out_new_thread),
    .out_runnable_count (out_runnable_count)
  );

endmodule
